// ===== src/disk_request_tag_allocator_macros.svh =====
// Assertion macros for the disk request tag allocator.
// Included by the top level; needs nothing else.
`ifndef DISK_REQUEST_TAG_ALLOCATOR_MACROS_SVH
`define DISK_REQUEST_TAG_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define DRA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DRA_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dra_pkg.sv =====
// Shared types and constants of the disk request tag allocator.
// No dependencies.
package dra_pkg;

    // Result codes
    localparam logic [1:0] RC_OK   = 2'd0;
    localparam logic [1:0] RC_BUSY = 2'd1;
    localparam logic [1:0] RC_BAD  = 2'd2;

    // Request kinds
    localparam logic REQ_ALLOC    = 1'b0;
    localparam logic REQ_COMPLETE = 1'b1;

    // Field widths
    localparam int CLIENT_ID_W   = 6;
    localparam int DISK_W        = 5;
    localparam int DISK_P1_W     = 6;
    localparam int USER_TAG_W    = 64;
    localparam int TAG_W         = 22;
    localparam int TAG_CLIENT_W  = 16;
    localparam int TAG_INDEX_W   = TAG_W - TAG_CLIENT_W;
    localparam int STATUS_W      = 32;
    localparam int COUNT_W       = 32;
    localparam int S_TDATA_W     = 136;
    localparam int M_TDATA_W     = 160;
    localparam int M_TUSER_W     = 3;

    // Control sequencer
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ===== src/dra_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/dra_slot_pick.sv =====
// Lowest-free-slot finder over one client's occupancy word.
// No dependencies.
module dra_slot_pick #(
    parameter int SLOTS = 32,
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
    input  logic [SLOTS-1:0] occupied,
    output logic             found,
    output logic [SW-1:0]    slot
);

    // Scan from the top so the lowest free slot wins
    always_comb begin
        found = 1'b0;
        slot  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!occupied[i]) begin
                found = 1'b1;
                slot  = SW'(i);
            end
        end
    end

endmodule

// ===== src/disk_request_tag_allocator.sv =====
// Top level of the disk request tag allocator: sequencer, tables, result register.
// Depends on dra_pkg, dra_ram, dra_slot_pick and the assertion macro header.
//
// Each request first reads the client's occupancy word and the slot tables from
// RAM; in the execute state it then picks the slot, writes back and registers the
// result, once the output register is free. A new request is taken only after the
// write-back, which keeps reads and writes of one entry apart. After reset the
// occupancy RAM is cleared, one client per cycle, before the first request is taken.
// A result waiting in the output register does not hold up the next request's read.
`include "disk_request_tag_allocator_macros.svh"

module disk_request_tag_allocator #(
    parameter int CLIENTS          = 64,
    parameter int SLOTS_PER_CLIENT = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request channel
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // client_id[5:0], disk_number[10:6], user_tag[74:11],
    // completion_tag[96:75], completion_status[128:97], zero fill
    input  logic [dra_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                          s_tuser,
    // result channel
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // issued_tag[21:0], done_disk[26:22], done_user_tag[90:27],
    // done_status[122:91], completions_seen[154:123], zero fill
    output logic [dra_pkg::M_TDATA_W-1:0] m_tdata,
    // result_code[1:0], deliver_to_client[2]
    output logic [dra_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int CW = $clog2(CLIENTS);
    localparam int SW = (SLOTS_PER_CLIENT > 1) ? $clog2(SLOTS_PER_CLIENT) : 1;
    localparam int AW = $clog2(CLIENTS * SLOTS_PER_CLIENT);
    localparam int ENTRIES = CLIENTS * SLOTS_PER_CLIENT;

    // Unpacked request fields
    logic [dra_pkg::CLIENT_ID_W-1:0]  in_client;
    logic [dra_pkg::DISK_W-1:0]       in_disk;
    logic [dra_pkg::USER_TAG_W-1:0]   in_utag;
    logic [dra_pkg::TAG_W-1:0]        in_ctag;
    logic [dra_pkg::STATUS_W-1:0]     in_status;
    logic [dra_pkg::TAG_CLIENT_W-1:0] ctag_client;
    logic [dra_pkg::TAG_INDEX_W-1:0]  ctag_index;

    assign in_client   = s_tdata[5:0];
    assign in_disk     = s_tdata[10:6];
    assign in_utag     = s_tdata[74:11];
    assign in_ctag     = s_tdata[96:75];
    assign in_status   = s_tdata[128:97];
    assign ctag_client = in_ctag[dra_pkg::TAG_CLIENT_W-1:0];
    assign ctag_index  = in_ctag[dra_pkg::TAG_W-1:dra_pkg::TAG_CLIENT_W];

    dra_pkg::state_t state_reg, state_next;

    logic accept;
    logic exec_fire;
    logic out_free;

    // Captured request
    logic                             kind_reg;
    logic                             bad_reg;
    logic                             tzero_reg;
    logic [CW-1:0]                    client_reg;
    logic [dra_pkg::CLIENT_ID_W-1:0]  client_id_reg;
    logic [dra_pkg::DISK_W-1:0]       disk_reg;
    logic [dra_pkg::USER_TAG_W-1:0]   utag_reg;
    logic [dra_pkg::STATUS_W-1:0]     status_reg;
    logic [AW-1:0]                    base_reg;
    logic [SW-1:0]                    cslot_reg;

    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [dra_pkg::COUNT_W-1:0] count_reg, count_next;

    // Request decode at accept
    logic [31:0]   cl32;
    logic [31:0]   slot32;
    logic [31:0]   base32;
    logic [31:0]   idx32;
    logic          in_bad;
    logic          in_tzero;
    logic [CW-1:0] in_caddr;

    always_comb begin
        in_tzero = (in_ctag == '0);
        if (s_tuser == dra_pkg::REQ_ALLOC) begin
            cl32   = 32'(in_client);
            in_bad = (cl32 >= 32'(CLIENTS));
        end else begin
            cl32   = 32'(ctag_client);
            in_bad = !in_tzero &&
                     ((cl32 >= 32'(CLIENTS)) || (ctag_index == '0) ||
                      (32'(ctag_index) > 32'(SLOTS_PER_CLIENT)));
        end
        in_caddr = cl32[CW-1:0];
        slot32   = 32'(ctag_index) - 32'd1;
        base32   = 32'(in_caddr) * 32'(SLOTS_PER_CLIENT);
        idx32    = base32 + 32'(slot32[SW-1:0]);
    end

    // Memories
    logic                        bm_we;
    logic [CW-1:0]               bm_waddr;
    logic [SLOTS_PER_CLIENT-1:0] bm_wdata;
    logic [SLOTS_PER_CLIENT-1:0] bm_rdata;
    logic                        tbl_we;
    logic [AW-1:0]               tbl_waddr;
    logic [dra_pkg::DISK_P1_W-1:0] dk_wdata;
    logic [dra_pkg::DISK_P1_W-1:0] dk_rdata;
    logic [dra_pkg::USER_TAG_W-1:0] ut_rdata;

    dra_ram #(.WIDTH(SLOTS_PER_CLIENT), .DEPTH(CLIENTS)) u_occ_ram (
        .aclk  (aclk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (accept),
        .raddr (in_caddr),
        .rdata (bm_rdata)
    );

    dra_ram #(.WIDTH(dra_pkg::DISK_P1_W), .DEPTH(ENTRIES)) u_disk_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (dk_wdata),
        .re    (accept),
        .raddr (idx32[AW-1:0]),
        .rdata (dk_rdata)
    );

    dra_ram #(.WIDTH(dra_pkg::USER_TAG_W), .DEPTH(ENTRIES)) u_utag_ram (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (utag_reg),
        .re    (accept),
        .raddr (idx32[AW-1:0]),
        .rdata (ut_rdata)
    );

    // Lowest free slot of the client
    logic          pick_found;
    logic [SW-1:0] pick_slot;

    dra_slot_pick #(.SLOTS(SLOTS_PER_CLIENT)) u_pick (
        .occupied (bm_rdata),
        .found    (pick_found),
        .slot     (pick_slot)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dra_pkg::ST_CLEAR: begin
                if (clr_cnt_reg == CW'(CLIENTS - 1)) state_next = dra_pkg::ST_IDLE;
            end
            dra_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = dra_pkg::ST_EXEC;
            end
            dra_pkg::ST_EXEC: begin
                if (out_free) state_next = dra_pkg::ST_IDLE;
            end
            default: state_next = dra_pkg::ST_CLEAR;
        endcase
    end

    logic m_valid_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Sequencer outputs
    logic clearing;
    always_comb begin
        s_tready  = 1'b0;
        exec_fire = 1'b0;
        clearing  = 1'b0;
        unique case (state_reg)
            dra_pkg::ST_CLEAR: clearing  = 1'b1;
            dra_pkg::ST_IDLE:  s_tready  = 1'b1;
            dra_pkg::ST_EXEC:  exec_fire = out_free;
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Execute: decisions on the read data
    logic alloc_ok;
    logic compl_ok;
    logic occ_bit;
    logic [31:0] wr_idx32;
    logic [dra_pkg::DISK_P1_W-1:0] stored_p1;
    logic [dra_pkg::DISK_P1_W-1:0] disk_m1;
    logic [31:0] slot_p1;

    always_comb begin
        alloc_ok  = (kind_reg == dra_pkg::REQ_ALLOC) && !bad_reg && pick_found;
        compl_ok  = (kind_reg == dra_pkg::REQ_COMPLETE) && !bad_reg && !tzero_reg;
        occ_bit   = bm_rdata[cslot_reg];
        stored_p1 = occ_bit ? dk_rdata : '0;
        disk_m1   = stored_p1 - dra_pkg::DISK_P1_W'(1);
        wr_idx32  = 32'(base_reg) + 32'(pick_slot);
        slot_p1   = 32'(pick_slot) + 32'd1;
        tbl_we    = exec_fire && alloc_ok;
        tbl_waddr = wr_idx32[AW-1:0];
        dk_wdata  = {1'b0, disk_reg} + dra_pkg::DISK_P1_W'(1);
    end

    // Occupancy write-back, or the clearing sweep
    always_comb begin
        bm_waddr = client_reg;
        bm_wdata = bm_rdata;
        bm_we    = exec_fire && (alloc_ok || compl_ok);
        if (clearing) begin
            bm_we    = 1'b1;
            bm_waddr = clr_cnt_reg;
            bm_wdata = '0;
        end else if (kind_reg == dra_pkg::REQ_ALLOC) begin
            bm_wdata[pick_slot] = 1'b1;
        end else begin
            bm_wdata[cslot_reg] = 1'b0;
        end
    end

    // Completion counter and clear counter
    always_comb begin
        count_next = count_reg;
        if (exec_fire && (kind_reg == dra_pkg::REQ_COMPLETE) && !bad_reg) begin
            count_next = count_reg + 32'd1;
        end
        clr_cnt_next = clearing ? clr_cnt_reg + CW'(1) : clr_cnt_reg;
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dra_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            count_reg   <= count_next;
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg      <= s_tuser;
            bad_reg       <= in_bad;
            tzero_reg     <= in_tzero;
            client_reg    <= in_caddr;
            client_id_reg <= in_client;
            disk_reg      <= in_disk;
            utag_reg      <= in_utag;
            status_reg    <= in_status;
            base_reg      <= base32[AW-1:0];
            cslot_reg     <= slot32[SW-1:0];
        end
    end

    // Result register
    logic [1:0]                     res_code_reg;
    logic                           res_deliver_reg;
    logic [dra_pkg::TAG_W-1:0]      res_tag_reg;
    logic [dra_pkg::DISK_W-1:0]     res_disk_reg;
    logic [dra_pkg::USER_TAG_W-1:0] res_utag_reg;
    logic [dra_pkg::STATUS_W-1:0]   res_status_reg;
    logic [dra_pkg::COUNT_W-1:0]    res_count_reg;

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            res_count_reg   <= count_next;
            res_tag_reg     <= '0;
            res_disk_reg    <= '0;
            res_utag_reg    <= '0;
            res_status_reg  <= '0;
            res_deliver_reg <= 1'b0;
            if (bad_reg) begin
                res_code_reg <= dra_pkg::RC_BAD;
            end else if (kind_reg == dra_pkg::REQ_ALLOC) begin
                if (pick_found) begin
                    res_code_reg <= dra_pkg::RC_OK;
                    res_tag_reg  <= {slot_p1[dra_pkg::TAG_INDEX_W-1:0],
                                     dra_pkg::TAG_CLIENT_W'(client_id_reg)};
                end else begin
                    res_code_reg <= dra_pkg::RC_BUSY;
                end
            end else begin
                res_code_reg <= dra_pkg::RC_OK;
                if (!tzero_reg) begin
                    res_disk_reg    <= disk_m1[dra_pkg::DISK_W-1:0];
                    res_utag_reg    <= ut_rdata;
                    res_status_reg  <= status_reg;
                    res_deliver_reg <= 1'b1;
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {res_deliver_reg, res_code_reg};
    assign m_tdata  = {5'd0, res_count_reg, res_status_reg, res_utag_reg,
                       res_disk_reg, res_tag_reg};

    // Checks
    `DRA_ASSERT_IMP(a_no_rw_overlap, aclk, aresetn, bm_we && !clearing, !accept,
        "occupancy write-back overlaps a new read")
    `DRA_ASSERT_NXT(a_accept_exec, aclk, aresetn, accept, state_reg == dra_pkg::ST_EXEC,
        "accepted request did not enter execute")
    `DRA_ASSERT_IMP(a_deliver_ok, aclk, aresetn, m_tvalid && m_tuser[2],
        m_tuser[1:0] == dra_pkg::RC_OK, "delivery carries a non-ok code")
    `DRA_ASSERT_IMP(a_clear_blocks, aclk, aresetn, clearing, !s_tready && !tbl_we,
        "request activity during the clearing sweep")

endmodule
